// File: src/bounded_list_deque_defines.svh
// Assertion macros used by the file that checks the list logic.
`ifndef BOUNDED_LIST_DEQUE_DEFINES_SVH
`define BOUNDED_LIST_DEQUE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BLD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bld_pkg.sv
package bld_pkg;

    // Default list capacity.
    localparam int DEPTH_DEFAULT = 64;

    // Field types of the transactions.
    typedef logic [2:0]         cmd_t;
    typedef logic [1:0]         status_t;
    typedef logic signed [31:0] data_t;

    // Command codes.
    localparam cmd_t CMD_PUSH   = 3'd0;
    localparam cmd_t CMD_APPEND = 3'd1;
    localparam cmd_t CMD_REMOVE = 3'd2;
    localparam cmd_t CMD_PRINT  = 3'd3;
    localparam cmd_t CMD_CLEAR  = 3'd4;

    // Status codes.
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // Controller states.
    typedef enum logic [0:0] {
        S_IDLE,
        S_PRINT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;       // execute the accepted input transaction
        logic emit;       // load one print result into the output register
        logic read_next;  // fetch the next list entry for print
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic empty;      // list holds no entries
        logic print_last; // entry being printed is the back of the list
    } dp_stat_t;

endpackage

// File: src/bld_if.sv
// Input channel: one command transaction.
interface bld_in_if;
    logic            valid;
    logic            ready;
    bld_pkg::cmd_t   cmd;
    bld_pkg::data_t  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Output channel: one result transaction.
interface bld_out_if;
    logic              valid;
    logic              ready;
    bld_pkg::status_t  status;
    bld_pkg::data_t    item;
    logic              item_valid;
    logic              last;

    modport source (output valid, output status, output item, output item_valid,
                    output last, input ready);
    modport sink   (input valid, input status, input item, input item_valid,
                    input last, output ready);
endinterface

// File: src/bld_ram.sv
module bld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port that holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bld_datapath.sv
module bld_datapath #(
    parameter int DEPTH = bld_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bld_pkg::ctl_cmd_t   ctl,
    input  bld_pkg::cmd_t       cmd,
    input  bld_pkg::data_t      value,
    input  logic                out_ready,
    output bld_pkg::dp_stat_t   stat,
    output logic                out_valid,
    output bld_pkg::status_t    status,
    output bld_pkg::data_t      item,
    output logic                item_valid,
    output logic                last
);

    import bld_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    data_t         item_reg, item_next;
    logic          item_valid_reg, item_valid_next;
    logic          last_reg, last_next;

    logic          full;
    logic          empty;
    logic          out_free;
    logic          print_last;
    logic          load;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    data_t         ram_rdata;

    // Fold a sum below twice the depth back into the ring.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
        return r[AW-1:0];
    endfunction

    bld_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // List status seen by the controller.
    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign print_last = ((SW'(idx_reg) + SW'(1)) == SW'(count_reg));

    assign stat.out_free   = out_free;
    assign stat.empty      = empty;
    assign stat.print_last = print_last;

    // Command execution, store access and result formation.
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        item_next       = item_reg;
        item_valid_next = item_valid_reg;
        last_next       = last_reg;
        load            = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        if (ctl.exec)
        begin
            item_next       = '0;
            item_valid_next = 1'b0;
            last_next       = 1'b1;
            status_next     = STATUS_OK;
            unique case (cmd)
                CMD_PUSH:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        head_next  = (head_reg == '0) ? AW'(DEPTH - 1) : (head_reg - AW'(1));
                        ram_we     = 1'b1;
                        ram_waddr  = head_next;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_APPEND:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = wrap(SW'(head_reg) + SW'(count_reg));
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    load = 1'b1;
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        head_next  = wrap(SW'(head_reg) + SW'(1));
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_PRINT:
                begin
                    if (empty)
                    begin
                        load        = 1'b1;
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        // Fetch the front entry; results follow from the controller.
                        ram_re    = 1'b1;
                        ram_raddr = head_reg;
                        idx_next  = '0;
                    end
                end
                CMD_CLEAR:
                begin
                    load       = 1'b1;
                    head_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                    // Unknown commands leave no trace.
                end
            endcase
        end
        else if (ctl.emit)
        begin
            load            = 1'b1;
            status_next     = STATUS_OK;
            item_next       = ram_rdata;
            item_valid_next = 1'b1;
            last_next       = print_last;
            if (ctl.read_next)
            begin
                ram_re    = 1'b1;
                ram_raddr = wrap(SW'(head_reg) + SW'(idx_reg) + SW'(1));
                idx_next  = idx_reg + AW'(1);
            end
        end

        // Output register: filled on a result, emptied when the sink takes it.
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        item_reg       <= item_next;
        item_valid_reg <= item_valid_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign item       = item_reg;
    assign item_valid = item_valid_reg;
    assign last       = last_reg;

endmodule

// File: src/bld_ctrl.sv
module bld_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bld_pkg::cmd_t      cmd,
    input  bld_pkg::dp_stat_t  stat,
    output logic               in_ready,
    output bld_pkg::ctl_cmd_t  ctl
);

    import bld_pkg::*;

    state_t state_reg, state_next;

    // Next state: a print of a non-empty list walks the entries.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.out_free && (cmd == CMD_PRINT) && !stat.empty)
                begin
                    state_next = S_PRINT;
                end
            end
            S_PRINT:
            begin
                if (stat.out_free && stat.print_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: take input only in idle with room in the output register.
    always_comb
    begin
        in_ready      = 1'b0;
        ctl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                ctl.exec = in_valid && stat.out_free;
            end
            S_PRINT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.read_next = !stat.print_last;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/bounded_list_deque.sv
// Push, append, remove, clear and empty-list print each give one result in the output register in
// the cycle after the transaction; one such command is taken per cycle while the output has
// room; unknown commands are taken with no result. Print of N entries holds off the input until
// its last result, one per cycle while the output has room, paced by the store's read register.
// Reset (rst_n, asynchronous, active low) empties the list and the output register at once;
// the entry store is not cleared and needs no clearing pass.
`include "bounded_list_deque_defines.svh"

module bounded_list_deque #(
    parameter int DEPTH = bld_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bld_in_if.sink     in_ch,
    bld_out_if.source  out_ch
);

    import bld_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;
    logic     in_ready;

    bld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .cmd      (in_ch.cmd),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    bld_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cmd        (in_ch.cmd),
        .value      (in_ch.value),
        .out_ready  (out_ch.ready),
        .stat       (stat),
        .out_valid  (out_ch.valid),
        .status     (out_ch.status),
        .item       (out_ch.item),
        .item_valid (out_ch.item_valid),
        .last       (out_ch.last)
    );

    assign in_ch.ready = in_ready;

    // A transaction is only taken when its result has a place to go.
    `BLD_ASSERT_IMPL(a_ready_needs_room, in_ready, stat.out_free, "input ready without output room")
    // Print steps never overlap an accepted transaction.
    `BLD_ASSERT_IMPL(a_emit_blocks_input, ctl.emit, !in_ready, "print step while input is open")
    // No fetch past the back of the list.
    `BLD_ASSERT_IMPL(a_no_read_past_last, ctl.read_next, !stat.print_last, "fetch beyond last entry")
    // An emitted print result is presented on the next cycle.
    `BLD_ASSERT_NEXT(a_emit_shows_item, ctl.emit, out_ch.valid && out_ch.item_valid, "print result lost")

endmodule
